[sv/clt_pkg.sv]
package clt_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_BYTES_BLANK = '0;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int MAX_RES = 3;

  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_PLAIN   = 3'd2;
  localparam logic [2:0] M_QOPEN   = 3'd3;
  localparam logic [2:0] M_QUOTED  = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;

  localparam logic [1:0] K_CHAR    = 2'd0;
  localparam logic [1:0] K_TOKEND  = 2'd1;
  localparam logic [1:0] K_LINEEND = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } result_t;

  typedef struct packed {
    logic [1:0]             cnt;
    result_t [MAX_RES-1:0]  res;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t b;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t b;
  } q_head_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       split_quote;
    logic       line_has_token;
  } front_stat_t;

endpackage

[sv/clt_front.sv]
module clt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_text_end,
  input  logic                 high_bytes_blank,
  input  logic                 q_full,
  output clt_pkg::q_wr_t       q_wr,
  output clt_pkg::front_stat_t stat
);

  typedef struct packed {
    logic [2:0]       mode;
    logic             lht;
    clt_pkg::bundle_t b;
  } step_t;

  logic [2:0] mode_r, mode_nxt;
  logic       sq_r, sq_nxt;
  logic       lht_r, lht_nxt;
  logic       acc;
  logic       split;
  logic       sq_tog;
  step_t      s;

  function automatic step_t emit(step_t st, logic [1:0] k, logic [7:0] c);
    step_t r;
    r = st;
    if (r.b.cnt != 2'd3) begin
      r.b.res[r.b.cnt].kind = k;
      r.b.res[r.b.cnt].ch = (k == clt_pkg::K_CHAR) ? c : 8'h00;
      r.b.cnt = r.b.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t token_end(step_t st);
    step_t r;
    r = emit(st, clt_pkg::K_TOKEND, 8'h00);
    r.lht = 1'b1;
    r.mode = clt_pkg::M_BETWEEN;
    return r;
  endfunction

  function automatic step_t finish_line(step_t st);
    step_t r;
    logic  open;
    r = st;
    open = 1'b0;
    if (r.mode == clt_pkg::M_SLASH) begin
      r = emit(r, clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
      open = 1'b1;
    end else if (r.mode == clt_pkg::M_PLAIN || r.mode == clt_pkg::M_QUOTED) begin
      open = 1'b1;
    end
    if (open) begin
      if (r.b.cnt <= 2'd1) begin
        r = emit(r, clt_pkg::K_TOKEND, 8'h00);
      end
      r.lht = 1'b1;
    end
    if (r.lht) begin
      r = emit(r, clt_pkg::K_LINEEND, 8'h00);
    end
    r.lht = 1'b0;
    r.mode = clt_pkg::M_BETWEEN;
    return r;
  endfunction

  function automatic step_t token_byte(step_t st, logic [7:0] c, logic hbb);
    step_t r;
    logic  blank;
    r = st;
    blank = (c <= clt_pkg::CH_SPACE) || (c[7] && hbb);
    case (r.mode)
      clt_pkg::M_SLASH: begin
        if (c == clt_pkg::CH_SLASH) begin
          r.mode = clt_pkg::M_COMMENT;
        end else if (c == clt_pkg::CH_SPACE) begin
          r = emit(r, clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
          r = token_end(r);
        end else begin
          r = emit(r, clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
          r = emit(r, clt_pkg::K_CHAR, c);
          r.mode = clt_pkg::M_PLAIN;
        end
      end
      clt_pkg::M_PLAIN: begin
        if (c == clt_pkg::CH_SPACE) begin
          r = token_end(r);
        end else begin
          r = emit(r, clt_pkg::K_CHAR, c);
        end
      end
      clt_pkg::M_QOPEN, clt_pkg::M_QUOTED: begin
        if (c == clt_pkg::CH_QUOTE) begin
          r = token_end(r);
        end else begin
          r = emit(r, clt_pkg::K_CHAR, c);
          r.mode = clt_pkg::M_QUOTED;
        end
      end
      clt_pkg::M_COMMENT: begin
        r.mode = clt_pkg::M_COMMENT;
      end
      default: begin
        r.mode = clt_pkg::M_BETWEEN;
        if (!blank) begin
          if (c == clt_pkg::CH_SLASH) begin
            r.mode = clt_pkg::M_SLASH;
          end else if (c == clt_pkg::CH_QUOTE) begin
            r.mode = clt_pkg::M_QOPEN;
          end else begin
            r = emit(r, clt_pkg::K_CHAR, c);
            r.mode = clt_pkg::M_PLAIN;
          end
        end
      end
    endcase
    return r;
  endfunction

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;

  always_comb begin
    sq_tog = sq_r ^ (in_ch == clt_pkg::CH_QUOTE);
    split = (in_ch == clt_pkg::CH_LF) || (in_ch == clt_pkg::CH_CR) ||
            ((in_ch == clt_pkg::CH_SEMI) && !sq_tog);
    s = '0;
    s.mode = mode_r;
    s.lht = lht_r;
    if (split) begin
      s = finish_line(s);
    end else begin
      s = token_byte(s, in_ch, high_bytes_blank);
    end
    if (in_text_end) begin
      s = finish_line(s);
    end
    mode_nxt = mode_r;
    lht_nxt = lht_r;
    sq_nxt = sq_r;
    if (acc) begin
      mode_nxt = s.mode;
      lht_nxt = s.lht;
      sq_nxt = in_text_end ? 1'b0 : sq_tog;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= clt_pkg::M_BETWEEN;
      sq_r <= 1'b0;
      lht_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      sq_r <= sq_nxt;
      lht_r <= lht_nxt;
    end
  end

  assign q_wr.push = acc && (s.b.cnt != 2'd0);
  assign q_wr.b = s.b;

  assign stat.mode = mode_r;
  assign stat.split_quote = sq_r;
  assign stat.line_has_token = lht_r;

endmodule

[sv/clt_queue.sv]
module clt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::q_wr_t   q_wr,
  output logic             q_full,
  output clt_pkg::q_head_t q_head,
  input  logic             q_pop
);

  clt_pkg::bundle_t           mem_r [clt_pkg::QDEPTH];
  logic [clt_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [clt_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [clt_pkg::QAW:0]      cnt_r, cnt_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign q_full = (cnt_r == (clt_pkg::QAW+1)'(clt_pkg::QDEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.b = mem_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_full;
  assign do_pop = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.b;
    end
  end

endmodule

[sv/clt_back.sv]
module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_ch,
  output logic             out_run_last
);

  logic [1:0]       idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [1:0]       kind_r;
  logic [7:0]       ch_r;
  logic             last_r;
  logic             load;
  logic             at_last;
  clt_pkg::result_t cur;

  assign cur = q_head.b.res[idx_r];
  assign at_last = (idx_r == q_head.b.cnt - 2'd1);
  assign load = q_head.valid && (!vld_r || out_ready);
  assign q_pop = load && at_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.kind;
      ch_r <= cur.ch;
      last_r <= at_last;
    end
  end

  assign out_valid = vld_r;
  assign out_kind = kind_r;
  assign out_ch = ch_r;
  assign out_run_last = last_r;

endmodule

[sv/command_line_tokenizer_unit.sv]
// path: results of a request pass through the queue memory and the output register;
//   further results of the same request follow one a cycle while out_ready is high
// throughput: one request per cycle while each gives at most one result and out_ready
//   is high; extra results hold the output stage, absorbed by a four-entry queue
// reset: synchronous active-low rst_n clears tokenizer state, queue and output valid;
//   high_bytes_blank resets to 1
module command_line_tokenizer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_ch,
  input  logic                       in_text_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_ch,
  output logic                       out_run_last,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [clt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [clt_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [clt_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic                 hbb_r, hbb_nxt;
  logic                 cfg_wr;
  logic                 sel_hbb;
  logic                 q_full;
  logic                 q_pop;
  clt_pkg::q_wr_t       q_wr;
  clt_pkg::q_head_t     q_head;
  clt_pkg::front_stat_t stat;

  assign cfg_pready = 1'b1;
  assign sel_hbb = (cfg_paddr[clt_pkg::CFG_AW-1:2] == clt_pkg::REG_HIGH_BYTES_BLANK);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign hbb_nxt = (cfg_wr && sel_hbb) ? cfg_pwdata[0] : hbb_r;
  assign cfg_prdata = sel_hbb ? {{(clt_pkg::CFG_DW-1){1'b0}}, hbb_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbb_r <= 1'b1;
    end else begin
      hbb_r <= hbb_nxt;
    end
  end

  clt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_text_end      (in_text_end),
    .high_bytes_blank (hbb_r),
    .q_full           (q_full),
    .q_wr             (q_wr),
    .stat             (stat)
  );

  clt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  clt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_ch       (out_ch),
    .out_run_last (out_run_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("queue written while full");

  a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_text_end) |=>
      (stat.mode == clt_pkg::M_BETWEEN && !stat.split_quote && !stat.line_has_token))
    else $error("tokenizer state not cleared at text end");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == clt_pkg::K_CHAR || out_kind == clt_pkg::K_TOKEND ||
                   out_kind == clt_pkg::K_LINEEND))
    else $error("illegal result kind");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (q_wr.b.cnt != 2'd0))
    else $error("empty request pushed");

endmodule

[verif/command_line_tokenizer_unit_tb.sv]
module command_line_tokenizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PEND_DEPTH   = 1024;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } tok_event_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_ch = '0;
  logic                       in_text_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic [1:0]                 out_kind;
  logic [7:0]                 out_ch;
  logic                       out_run_last;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [clt_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [clt_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [clt_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  command_line_tokenizer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_ch       (out_ch),
    .out_run_last (out_run_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tokenizer state as the block should hold it
  logic       mdl_high_blank;
  logic       mdl_split_quote;
  logic [2:0] mdl_mode;
  logic       mdl_line_has_token;

  tok_event_t byte_events [clt_pkg::MAX_RES];
  int         byte_cnt = 0;
  tok_event_t pend_mem [PEND_DEPTH];
  int         pend_wr = 0;
  int         pend_rd = 0;

  int  errors = 0;
  bit  in_free_run = 1'b0;
  bit  out_free_run = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  function automatic void add_event(logic [1:0] kind, logic [7:0] c);
    tok_event_t e;
    if (byte_cnt >= clt_pkg::MAX_RES) return;
    e.kind = kind;
    e.ch   = (kind == clt_pkg::K_CHAR) ? c : 8'h00;
    e.last = 1'b0;
    byte_events[byte_cnt] = e;
    byte_cnt++;
  endfunction

  function automatic void close_token();
    add_event(clt_pkg::K_TOKEND, 8'h00);
    mdl_line_has_token = 1'b1;
    mdl_mode = clt_pkg::M_BETWEEN;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c <= clt_pkg::CH_SPACE) || (c[7] && mdl_high_blank);
  endfunction

  function automatic void close_line();
    bit open;
    open = 1'b0;
    if (mdl_mode == clt_pkg::M_SLASH) begin
      add_event(clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
      open = 1'b1;
    end else if (mdl_mode == clt_pkg::M_PLAIN || mdl_mode == clt_pkg::M_QUOTED) begin
      open = 1'b1;
    end
    if (open) begin
      // with a held slash and a text end the line end also closes the token
      if (byte_cnt + 2 <= clt_pkg::MAX_RES) add_event(clt_pkg::K_TOKEND, 8'h00);
      mdl_line_has_token = 1'b1;
    end
    if (mdl_line_has_token) add_event(clt_pkg::K_LINEEND, 8'h00);
    mdl_line_has_token = 1'b0;
    mdl_mode = clt_pkg::M_BETWEEN;
  endfunction

  function automatic void token_byte(logic [7:0] c);
    case (mdl_mode)
      clt_pkg::M_SLASH: begin
        if (c == clt_pkg::CH_SLASH) begin
          mdl_mode = clt_pkg::M_COMMENT;
        end else if (c == clt_pkg::CH_SPACE) begin
          add_event(clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
          close_token();
        end else begin
          add_event(clt_pkg::K_CHAR, clt_pkg::CH_SLASH);
          add_event(clt_pkg::K_CHAR, c);
          mdl_mode = clt_pkg::M_PLAIN;
        end
      end
      clt_pkg::M_PLAIN: begin
        if (c == clt_pkg::CH_SPACE) close_token();
        else add_event(clt_pkg::K_CHAR, c);
      end
      clt_pkg::M_QOPEN, clt_pkg::M_QUOTED: begin
        if (c == clt_pkg::CH_QUOTE) begin
          close_token();
        end else begin
          add_event(clt_pkg::K_CHAR, c);
          mdl_mode = clt_pkg::M_QUOTED;
        end
      end
      clt_pkg::M_COMMENT: begin
      end
      default: begin
        mdl_mode = clt_pkg::M_BETWEEN;
        if (!is_blank(c)) begin
          if (c == clt_pkg::CH_SLASH) begin
            mdl_mode = clt_pkg::M_SLASH;
          end else if (c == clt_pkg::CH_QUOTE) begin
            mdl_mode = clt_pkg::M_QOPEN;
          end else begin
            add_event(clt_pkg::K_CHAR, c);
            mdl_mode = clt_pkg::M_PLAIN;
          end
        end
      end
    endcase
  endfunction

  function automatic void predict_byte_events(logic [7:0] c, logic text_end);
    byte_cnt = 0;
    if (c == clt_pkg::CH_QUOTE) mdl_split_quote = ~mdl_split_quote;
    if (c == clt_pkg::CH_LF || c == clt_pkg::CH_CR ||
        (c == clt_pkg::CH_SEMI && !mdl_split_quote)) close_line();
    else token_byte(c);
    if (text_end) begin
      close_line();
      mdl_split_quote = 1'b0;
    end
    if (byte_cnt > 0) byte_events[byte_cnt-1].last = 1'b1;
    for (int i = 0; i < byte_cnt; i++) begin
      pend_mem[pend_wr % PEND_DEPTH] = byte_events[i];
      pend_wr++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_free_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 38) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 52) return clt_pkg::CH_SPACE;
    if (r < 60) return clt_pkg::CH_QUOTE;
    if (r < 68) return clt_pkg::CH_SLASH;
    if (r < 73) return clt_pkg::CH_SEMI;
    if (r < 78) return clt_pkg::CH_LF;
    if (r < 81) return clt_pkg::CH_CR;
    if (r < 86) return 8'($urandom_range(0, 31));
    if (r < 92) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic text_end);
    int gap;
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_text_end <= text_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte_events(c, text_end);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit end_at_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_at_last && (i == s.len() - 1));
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while ((pend_wr - pend_rd) > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [clt_pkg::CFG_AW-1:0] addr,
                            input logic [clt_pkg::CFG_DW-1:0] wdata,
                            output logic [clt_pkg::CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_high_blank_reg();
    logic [clt_pkg::CFG_DW-1:0] rd;
    cfg_access(1'b0, {clt_pkg::REG_HIGH_BYTES_BLANK, 2'b00}, '0, rd);
    if (rd[0] !== mdl_high_blank) begin
      errors++;
      $display("%0t: high_bytes_blank read expected %0d actual %0d", $time, mdl_high_blank, rd);
    end
  endtask

  task automatic set_high_blank(input logic v);
    logic [clt_pkg::CFG_DW-1:0] rd;
    wait_drained(DRAIN_CYCLES);
    cfg_access(1'b1, {clt_pkg::REG_HIGH_BYTES_BLANK, 2'b00},
               {{(clt_pkg::CFG_DW-1){1'b0}}, v}, rd);
    mdl_high_blank = v;
    check_high_blank_reg();
  endtask

  task automatic test_reset_value();
    check_high_blank_reg();
  endtask

  task automatic test_directed_text();
    send_text("//x", 1'b0);
    send_byte(clt_pkg::CH_LF, 1'b0);
    send_text("/ /a", 1'b1);
    send_text("\"a\"b \"\";", 1'b0);
    send_text("a\";", 1'b0);
    send_byte(clt_pkg::CH_CR, 1'b0);
    send_text("\"", 1'b0);
    send_byte(clt_pkg::CH_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("/", 1'b1);
    send_text("\"x", 1'b1);
    send_text("b;", 1'b1);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_high_bytes_as_text();
    set_high_blank(1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(clt_pkg::CH_SPACE, 1'b0);
    send_byte(8'hfe, 1'b1);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++) send_byte(pick_text_byte(), 1'b0);
    // mid-text hold-off until the block has nothing left to give
    wait_drained(0);
    for (int i = 0; i < 12; i++) send_byte(pick_text_byte(), i == 11);
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < 4; phase++) begin
      set_high_blank(phase[0]);
      in_free_run  = (phase == 1);
      out_free_run = (phase == 1);
      for (int i = 0; i < 42; i++) begin
        if (phase != 1 && i % 16 == 0) in_free_run = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else send_byte(pick_text_byte(), $urandom_range(0, 19) == 0);
      end
      send_byte(pick_text_byte(), 1'b1);
    end
    in_free_run  = 1'b0;
    out_free_run = 1'b0;
  endtask

  always @(posedge clk) begin : out_stall
    int r;
    if (!rst_n || out_free_run) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
      end else if (r < 93) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(5, 30);
      end
    end
  end

  always @(posedge clk) begin : result_check
    tok_event_t got;
    tok_event_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_kind;
      got.ch   = out_ch;
      got.last = out_run_last;
      if ((pend_wr - pend_rd) == 0) begin
        errors++;
        $display("%0t: expected no result, actual kind %0d ch %02h last %0d",
                 $time, got.kind, got.ch, got.last);
      end else begin
        want = pend_mem[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got.kind !== want.kind || got.ch !== want.ch || got.last !== want.last) begin
          errors++;
          $display("%0t: expected kind %0d ch %02h last %0d, actual kind %0d ch %02h last %0d",
                   $time, want.kind, want.ch, want.last, got.kind, got.ch, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("command_line_tokenizer_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    mdl_high_blank     = 1'b1;
    mdl_split_quote    = 1'b0;
    mdl_mode           = clt_pkg::M_BETWEEN;
    mdl_line_has_token = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value();
    test_directed_text();
    test_high_bytes_as_text();
    test_drain_pause();
    test_random_text();
    wait_drained(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("command_line_tokenizer_unit_tb: done, clean");
    end else begin
      $display("command_line_tokenizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
